// ===== hdl/psv_pkg.sv =====
// ---------------------------------------------------------------------------
// psv_pkg
// Shared widths, command and register codes, reset values and the output
// saturation function for the plucked string voice.
// ---------------------------------------------------------------------------
package psv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int LEN_W      = 13;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Q1.15 fraction bits dropped after each product.
  localparam int FRAC_W  = 15;
  // Widest multiplier operand is the sum of two scaled products.
  localparam int PART_W  = 18;
  localparam int OPND_W  = PART_W + 1;
  localparam int PROD_W  = COEF_W + 1 + OPND_W;
  localparam int SHIFT_W = PROD_W - FRAC_W;

  localparam int DEFAULT_MAX_LENGTH = 4096;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_START = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TABLE_LENGTH = 2'd0;
  localparam cfg_idx_t REG_DECAY_GAIN   = 2'd1;
  localparam cfg_idx_t REG_WEIGHT_A     = 2'd2;
  localparam cfg_idx_t REG_WEIGHT_B     = 2'd3;

  localparam logic [LEN_W-1:0]  RST_TABLE_LENGTH = 13'd100;
  localparam logic [COEF_W-1:0] RST_DECAY_GAIN   = 16'd32440;
  localparam logic [COEF_W-1:0] RST_WEIGHT       = 16'd16384;

  // Clamp a scaled product to the signed 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SHIFT_W-1:0] v);
    logic [SHIFT_W-SAMPLE_W:0] hi;
    hi = v[SHIFT_W-1:SAMPLE_W-1];
    if (hi == '0 || hi == '1) begin
      return v[SAMPLE_W-1:0];
    end else if (v[SHIFT_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/plucked_string_synth_voice.sv =====
// ---------------------------------------------------------------------------
// plucked_string_synth_voice
// Karplus-Strong string voice: a delay line recirculated through a weighted
// two-tap average and a decay gain, all in Q1.15.
//
// Input channel (in_valid/in_ready) carries cmd and sample_in. A start item
// rewinds the read and load pointers and clears the last output; a load item
// writes sample_in into the delay line; a tick item produces one sample_out on
// the output channel (out_valid/out_ready). Any other command is dropped.
// Start and load items leave the voice idle and ready for the next item. A
// tick passes from acceptance to the result appearing in the output register
// through one memory read and three passes through the shared multiplier with
// a sum between them; no new item is taken until the tick has written back.
// If a previous result has not yet been taken, the tick holds in its final
// step until out_ready frees the output register.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and should only be written while the voice is idle.
// Reset returns the registers to their defaults and clears the pointers and
// last output; the delay line is not cleared and must be loaded before ticks.
// ---------------------------------------------------------------------------
module plucked_string_synth_voice #(
  parameter int MAX_LENGTH = psv_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [psv_pkg::CMD_W-1:0]             cmd,
  input  logic signed [psv_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [psv_pkg::SAMPLE_W-1:0]   sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psv_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import psv_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LENGTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULA = 6'b000010,
    S_MULB = 6'b000100,
    S_SUM  = 6'b001000,
    S_MULG = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t state;

  logic [LEN_W-1:0]  table_length;
  logic [COEF_W-1:0] decay_gain;
  logic [COEF_W-1:0] weight_a;
  logic [COEF_W-1:0] weight_b;

  logic [AW-1:0]              rd_ptr;
  logic [AW-1:0]              ld_ptr;
  logic [AW-1:0]              idx;
  logic signed [SAMPLE_W-1:0] last_output;
  logic signed [PART_W-1:0]   pa;
  logic signed [OPND_W-1:0]   s_sum;

  logic                       accept;
  logic                       wb_go;
  logic [LW-1:0]              len_ext;
  logic [LW-1:0]              eff_len;
  logic [AW-1:0]              tick_idx;
  logic [LW-1:0]              idx_inc;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [PART_W-1:0]   pb;

  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  logic                       mul_en;
  logic [COEF_W-1:0]          mul_coef;
  logic signed [OPND_W-1:0]   mul_opnd;
  logic signed [SHIFT_W-1:0]  mul_result;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign wb_go     = (state == S_WB) && (!out_valid || out_ready);

  // A zero length behaves as one, and a length past the memory is capped.
  assign len_ext  = LW'(table_length);
  assign eff_len  = (len_ext == '0) ? LW'(1) : ((len_ext > MAX_LEN_L) ? MAX_LEN_L : len_ext);
  assign tick_idx = (LW'(rd_ptr) < eff_len) ? rd_ptr : '0;
  assign idx_inc  = LW'(idx) + LW'(1);

  assign y_sat = sat16(mul_result);
  assign pb    = mul_result[PART_W-1:0];

  assign mem_we    = (accept && cmd == CMD_LOAD) || wb_go;
  assign mem_addr  = wb_go ? idx : ((cmd == CMD_LOAD) ? ld_ptr : tick_idx);
  assign mem_wdata = wb_go ? y_sat : sample_in;

  assign mul_en = (state == S_MULA) || (state == S_MULB) || (state == S_MULG);

  always_comb begin
    priority if (state == S_MULA) begin
      mul_coef = weight_a;
      mul_opnd = {{(OPND_W-SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata};
    end else if (state == S_MULB) begin
      mul_coef = weight_b;
      mul_opnd = {{(OPND_W-SAMPLE_W){last_output[SAMPLE_W-1]}}, last_output};
    end else begin
      mul_coef = decay_gain;
      mul_opnd = s_sum;
    end
  end

  psv_delay_mem #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  psv_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .coef   (mul_coef),
    .opnd   (mul_opnd),
    .result (mul_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= RST_TABLE_LENGTH;
      decay_gain   <= RST_DECAY_GAIN;
      weight_a     <= RST_WEIGHT;
      weight_b     <= RST_WEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TABLE_LENGTH: table_length <= cfg_data[LEN_W-1:0];
        REG_DECAY_GAIN:   decay_gain   <= cfg_data[COEF_W-1:0];
        REG_WEIGHT_A:     weight_a     <= cfg_data[COEF_W-1:0];
        REG_WEIGHT_B:     weight_b     <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_ptr      <= '0;
      ld_ptr      <= '0;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_START: begin
                rd_ptr      <= '0;
                ld_ptr      <= '0;
                last_output <= '0;
              end
              CMD_LOAD: begin
                ld_ptr <= (ld_ptr == LAST_ADDR) ? '0 : ld_ptr + AW'(1);
              end
              CMD_TICK: begin
                state <= S_MULA;
              end
              default: begin
              end
            endcase
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_SUM;
        S_SUM:  state <= S_MULG;
        S_MULG: state <= S_WB;
        S_WB: begin
          if (wb_go) begin
            state       <= S_IDLE;
            last_output <= y_sat;
            rd_ptr      <= (idx_inc >= eff_len) ? '0 : idx_inc[AW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_TICK) begin
      idx <= tick_idx;
    end
    if (state == S_MULB) begin
      pa <= mul_result[PART_W-1:0];
    end
    if (state == S_SUM) begin
      s_sum <= {pa[PART_W-1], pa} + {pb[PART_W-1], pb};
    end
    if (wb_go) begin
      sample_out <= y_sat;
    end
  end

  a_rd_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    LW'(rd_ptr) < MAX_LEN_L)
    else $error("read pointer beyond delay line");

  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_TICK) |-> ##5 (state == S_WB))
    else $error("tick did not reach write-back on schedule");

  a_short_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd != CMD_TICK) |=> (state == S_IDLE))
    else $error("start or load item left the voice busy");

  a_wb_result: assert property (@(posedge clk) disable iff (rst)
    wb_go |=> (state == S_IDLE && out_valid && sample_out == last_output))
    else $error("write-back did not present the new sample");

endmodule

// ===== hdl/psv_delay_mem.sv =====
// ---------------------------------------------------------------------------
// psv_delay_mem
// Single-port delay line memory with a registered read port.
// ---------------------------------------------------------------------------
module psv_delay_mem #(
  parameter int DEPTH = psv_pkg::DEFAULT_MAX_LENGTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        addr,
  input  logic signed [psv_pkg::SAMPLE_W-1:0]  wdata,
  output logic signed [psv_pkg::SAMPLE_W-1:0]  rdata
);
  import psv_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/psv_mul.sv =====
// ---------------------------------------------------------------------------
// psv_mul
// Shared Q1.15 multiplier: unsigned coefficient times signed operand, with a
// registered product and a floor scaling by 2^-15.
// ---------------------------------------------------------------------------
module psv_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic [psv_pkg::COEF_W-1:0]          coef,
  input  logic signed [psv_pkg::OPND_W-1:0]   opnd,
  output logic signed [psv_pkg::SHIFT_W-1:0]  result
);
  import psv_pkg::*;

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed({1'b0, coef}) * opnd;
    end
  end

  // Dropping the low bits of a two's complement value rounds towards minus infinity.
  assign result = prod[PROD_W-1:FRAC_W];

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the plucked string voice. A scripted opening
// covers weights and gain at their limits, saturation, the ignored command,
// out-of-range table lengths and a read pointer left past a shortened table.
// It then plays a note on the longest table, and random notes under changing
// settings with random gaps on both channels.
// Every output sample is checked, against a value from the plan or an in-bench model of the voice.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psv_pkg::*;

  localparam int MAX_LEN     = DEFAULT_MAX_LENGTH;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 12;
  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam int SEND_IDLE [4]  = '{0, 49, 0, 30};
  localparam int RECV_STALL [4] = '{0, 0, 49, 30};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  cmd_t                       cmd = CMD_START;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index = REG_TABLE_LENGTH;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  always #6 clk = ~clk;

  plucked_string_synth_voice dut (
    .clk, .rst,
    .in_valid, .in_ready, .cmd, .sample_in,
    .out_valid, .out_ready, .sample_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Shadow of the voice: delay line, pointers, last output and registers.
  logic signed [SAMPLE_W-1:0] line_mem [MAX_LEN];
  bit                         line_written [MAX_LEN];
  int unsigned                read_ptr = 0;
  int unsigned                load_ptr = 0;
  logic signed [SAMPLE_W-1:0] prev_out = '0;
  logic [LEN_W-1:0]           len_reg  = RST_TABLE_LENGTH;
  logic [COEF_W-1:0]          gain_reg = RST_DECAY_GAIN;
  logic [COEF_W-1:0]          wa_reg   = RST_WEIGHT;
  logic [COEF_W-1:0]          wb_reg   = RST_WEIGHT;

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int errors          = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int notes_played    = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int cycle_count     = 0;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    cmd_t        op;
    logic [15:0] value;
    logic        typed;
    logic [15:0] want;
  } plan_row_t;

  plan_row_t plan [27] = '{
    '{ROW_REG,  REG_TABLE_LENGTH, CMD_START,  16'd2,     1'b0, 16'd0},
    '{ROW_REG,  REG_DECAY_GAIN,   CMD_START,  16'd32768, 1'b0, 16'd0},
    '{ROW_REG,  REG_WEIGHT_A,     CMD_START,  16'd32768, 1'b0, 16'd0},
    '{ROW_REG,  REG_WEIGHT_B,     CMD_START,  16'd0,     1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_START,  16'h0000,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_LOAD,   16'h7FFF,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_LOAD,   16'h8000,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b1, 16'h7FFF},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'hFFFF,  1'b1, 16'h8000},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_UNUSED, 16'h5A5A,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b1, 16'h7FFF},
    '{ROW_REG,  REG_WEIGHT_A,     CMD_START,  16'hFFFF,  1'b0, 16'd0},
    '{ROW_REG,  REG_WEIGHT_B,     CMD_START,  16'hFFFF,  1'b0, 16'd0},
    '{ROW_REG,  REG_DECAY_GAIN,   CMD_START,  16'hFFFF,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b0, 16'd0},
    '{ROW_REG,  REG_TABLE_LENGTH, CMD_START,  16'd0,     1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b0, 16'd0},
    '{ROW_REG,  REG_TABLE_LENGTH, CMD_START,  16'hFFFF,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b0, 16'd0},
    '{ROW_REG,  REG_TABLE_LENGTH, CMD_START,  16'd1,     1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b0, 16'd0},
    '{ROW_REG,  REG_DECAY_GAIN,   CMD_START,  16'd0,     1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b1, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_START,  16'hFFFF,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_LOAD,   16'hA5A5,  1'b0, 16'd0},
    '{ROW_ITEM, REG_TABLE_LENGTH, CMD_TICK,   16'h0000,  1'b1, 16'd0}
  };

  function automatic int unsigned eff_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return 32'(len_reg);
  endfunction

  // A pointer left at or past a shortened table reads entry zero instead.
  function automatic int unsigned read_index();
    return (read_ptr < eff_length()) ? read_ptr : 0;
  endfunction

  function automatic void voice_next(input cmd_t op, input logic [15:0] value,
                                     output bit produced,
                                     output logic signed [SAMPLE_W-1:0] result);
    int unsigned idx;
    longint      mix;
    longint      scaled;
    produced = 1'b0;
    result   = '0;
    case (op)
      CMD_START: begin
        read_ptr = 0;
        load_ptr = 0;
        prev_out = '0;
      end
      CMD_LOAD: begin
        line_mem[IDX_W'(load_ptr)]     = value;
        line_written[IDX_W'(load_ptr)] = 1'b1;
        load_ptr = (load_ptr + 1) % MAX_LEN;
      end
      CMD_TICK: begin
        idx = read_index();
        // Arithmetic shifts on signed products give the floor of each quotient.
        mix = ((longint'(wa_reg) * longint'(line_mem[IDX_W'(idx)])) >>> FRAC_W)
            + ((longint'(wb_reg) * longint'(prev_out)) >>> FRAC_W);
        scaled = (longint'(gain_reg) * mix) >>> FRAC_W;
        if (scaled > 32767) result = 16'sh7FFF;
        else if (scaled < -32768) result = 16'sh8000;
        else result = scaled[SAMPLE_W-1:0];
        line_mem[IDX_W'(idx)] = result;
        prev_out      = result;
        idx++;
        read_ptr = (idx >= eff_length()) ? 0 : idx;
        produced = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] noise_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input cmd_t op, input logic [15:0] value,
                           input bit typed = 1'b0, input logic [15:0] want = '0);
    bit                         produced;
    logic signed [SAMPLE_W-1:0] got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    sample_in <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    voice_next(op, value, produced, got);
    if (produced) expected_samples.insert(expected_samples.size(), typed ? want : got);
  endtask

  // Ticks only where the entry under the read pointer holds a loaded value, and sends a load otherwise.
  task automatic tick_or_fill();
    if (line_written[IDX_W'(read_index())]) send_item(CMD_TICK, noise_sample());
    else send_item(CMD_LOAD, noise_sample());
  endtask

  // Start and load items leave no result, so a short pad follows the drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TABLE_LENGTH: len_reg  = value[LEN_W-1:0];
      REG_DECAY_GAIN:   gain_reg = value;
      REG_WEIGHT_A:     wa_reg   = value;
      REG_WEIGHT_B:     wb_reg   = value;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : sample_check
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: sample_out %0d with no result expected", $time, sample_out);
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (sample_out !== want) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want, sample_out);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned stop_at;
    int unsigned len;
    int unsigned n_load;
    int unsigned n_tick;
    logic [15:0] len_val;
    logic [15:0] gain;
    logic [15:0] wa;
    logic [15:0] wb;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        send_item(plan[r].op, plan[r].value, plan[r].typed, plan[r].want);
      end
    end

    // Longest table, with a short excitation at its start.
    wait_idle();
    write_reg(REG_TABLE_LENGTH, 16'd4096);
    write_reg(REG_DECAY_GAIN, RST_DECAY_GAIN);
    write_reg(REG_WEIGHT_A, RST_WEIGHT);
    write_reg(REG_WEIGHT_B, RST_WEIGHT);
    send_item(CMD_START, noise_sample());
    repeat (160) send_item(CMD_LOAD, noise_sample());
    repeat (48) tick_or_fill();
    notes_played++;

    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        wait_idle();
        send_idle_pct  = SEND_IDLE[p];
        recv_stall_pct = RECV_STALL[p];
        case ($urandom_range(9))
          0:       len_val = 16'($urandom_range(0, 1));
          1:       len_val = RST_TABLE_LENGTH;
          default: len_val = 16'($urandom_range(2, 48));
        endcase
        case ($urandom_range(3))
          0:       gain = 16'd32768;
          1:       gain = 16'($urandom_range(0, 65535));
          default: gain = 16'($urandom_range(30000, 32767));
        endcase
        if ($urandom_range(3) == 0) begin
          wa = 16'($urandom_range(0, 65535));
          wb = 16'($urandom_range(0, 65535));
        end else begin
          wa = 16'($urandom_range(0, 32768));
          wb = 16'd32768 - wa;
        end
        write_reg(REG_TABLE_LENGTH, len_val);
        write_reg(REG_DECAY_GAIN, gain);
        write_reg(REG_WEIGHT_A, wa);
        write_reg(REG_WEIGHT_B, wb);

        stop_at = items_sent + 150;
        // Carry on with the previous note first, so a pointer beyond a
        // shortened table gets exercised.
        repeat (4) tick_or_fill();
        while (items_sent < stop_at) begin
          len = eff_length();
          case ($urandom_range(9))
            0:       n_load = $urandom_range(1, len);
            1:       n_load = len + $urandom_range(1, 8);
            default: n_load = len;
          endcase
          n_tick = $urandom_range(len, 4 * len);
          if (n_tick > 160) n_tick = 160;
          send_item(CMD_START, noise_sample());
          repeat (n_load) send_item(CMD_LOAD, noise_sample());
          repeat (n_tick) begin
            if ($urandom_range(15) == 0) begin
              case ($urandom_range(2))
                0:       send_item(CMD_UNUSED, noise_sample());
                1:       send_item(CMD_LOAD, noise_sample());
                default: send_item(CMD_START, noise_sample());
              endcase
            end else begin
              tick_or_fill();
            end
          end
          notes_played++;
        end
      end
    end

    wait_idle();
    $display("Checked %0d output samples from %0d items across %0d notes.",
             results_checked, items_sent, notes_played);
    $display("Made %0d register writes, with sender gaps and output stalls up to 49%%.",
             reg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
